[rtl/core/iprt_pkg.sv]
`timescale 1ns / 1ps

package iprt_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int DEVICE_BITS = 4;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  // Field widths fixed by the stream format
  localparam int ADDR_W      = 32;
  localparam int PLEN_W      = 6;
  localparam int DEV_FIELD_W = 4;
  localparam int REQ_W       = 2;
  localparam int STAT_W      = 2;
  localparam int ENTRY_W     = 2 * ADDR_W + PLEN_W + DEVICE_BITS;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_ADD    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

  // Status codes
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_FAIL     = 2'd1;
  localparam logic [STAT_W-1:0] ST_NO_ROUTE = 2'd2;

  localparam logic [PLEN_W-1:0] PLEN_MAX = 6'd32;

  // One stored route
  typedef struct packed {
    logic [ADDR_W-1:0]      src;
    logic [ADDR_W-1:0]      tgt;
    logic [PLEN_W-1:0]      plen;
    logic [DEVICE_BITS-1:0] dev;
  } route_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // latch request, restart scan
    logic scan;    // issue one table read
    logic commit;  // apply update and register result
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;  // read of the last slot is being issued
    logic out_free;   // output register can take a result this cycle
  } dp_stat_t;

  // Interface field to stored device width
  function automatic logic [DEVICE_BITS-1:0] dev_from_field(
    input logic [DEV_FIELD_W-1:0] d
  );
    logic [DEVICE_BITS-1:0] r;
    for (int i = 0; i < DEVICE_BITS; i++) begin
      r[i] = (i < DEV_FIELD_W) ? d[i] : 1'b0;
    end
    return r;
  endfunction

  // Stored device width to interface field
  function automatic logic [DEV_FIELD_W-1:0] dev_to_field(
    input logic [DEVICE_BITS-1:0] d
  );
    logic [DEV_FIELD_W-1:0] r;
    for (int i = 0; i < DEV_FIELD_W; i++) begin
      r[i] = (i < DEVICE_BITS) ? d[i] : 1'b0;
    end
    return r;
  endfunction

  // True when the leading plen bits of dst and tgt agree (plen up to 32)
  function automatic logic prefix_covers(
    input logic [ADDR_W-1:0] dst,
    input logic [ADDR_W-1:0] tgt,
    input logic [PLEN_W-1:0] plen
  );
    logic [ADDR_W-1:0] mask;
    mask = ~({ADDR_W{1'b1}} >> plen);
    return (plen <= PLEN_MAX) && (((dst ^ tgt) & mask) == '0);
  endfunction

endpackage

[rtl/core/iprt_ram.sv]
`timescale 1ns / 1ps

module iprt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/iprt_ctrl.sv]
`timescale 1ns / 1ps

module iprt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  iprt_pkg::dp_stat_t stat,
  output iprt_pkg::ctl_cmd_t cmd
);

  import iprt_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_last) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (stat.out_free) state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Commands
  assign in_tready  = (state_r == S_IDLE);
  assign cmd.load   = (state_r == S_IDLE) && in_tvalid;
  assign cmd.scan   = (state_r == S_SCAN);
  assign cmd.commit = (state_r == S_COMMIT) && stat.out_free;

endmodule

[rtl/core/iprt_datapath.sv]
`timescale 1ns / 1ps

module iprt_datapath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  iprt_pkg::ctl_cmd_t                   cmd,
  output iprt_pkg::dp_stat_t                   stat,
  // request fields
  input  logic [iprt_pkg::REQ_W-1:0]           req_type,
  input  logic [iprt_pkg::ADDR_W-1:0]          source_addr,
  input  logic [iprt_pkg::ADDR_W-1:0]          target_addr,
  input  logic [iprt_pkg::PLEN_W-1:0]          prefix_len,
  input  logic [iprt_pkg::DEV_FIELD_W-1:0]     device_id,
  input  logic [iprt_pkg::ADDR_W-1:0]          dest_addr,
  input  logic                                 source_has_iface,
  // result register
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [iprt_pkg::STAT_W-1:0]          status,
  output logic [iprt_pkg::ADDR_W-1:0]          hit_source,
  output logic [iprt_pkg::ADDR_W-1:0]          hit_target,
  output logic [iprt_pkg::PLEN_W-1:0]          hit_prefix_len,
  output logic [iprt_pkg::DEV_FIELD_W-1:0]     hit_device,
  output logic                                 hit_is_default
);

  import iprt_pkg::*;

  // Latched request
  logic [REQ_W-1:0]  req_r;
  route_t            rq_r;
  logic [ADDR_W-1:0] dst_r;
  logic              iface_r;

  // Scan pointer and read pipeline
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] eidx_r;
  logic             rd_vld_r;
  logic [ENTRY_W-1:0] rd_data;
  route_t           ent;
  logic             ent_valid;

  // Scan findings
  logic             eq_found_r;
  logic [IDX_W-1:0] eq_idx_r;
  logic             free_found_r;
  logic [IDX_W-1:0] free_idx_r;
  logic             best_found_r;
  route_t           best_r;

  // Slot valid bits and default route
  logic [TABLE_DEPTH-1:0] valid_r;
  logic                   def_valid_r;
  logic [ADDR_W-1:0]      def_src_r;
  logic [ADDR_W-1:0]      def_tgt_r;
  logic [DEVICE_BITS-1:0] def_dev_r;

  // Result register
  logic                   out_valid_r;
  logic [STAT_W-1:0]      out_status_r;
  logic [ADDR_W-1:0]      out_src_r;
  logic [ADDR_W-1:0]      out_tgt_r;
  logic [PLEN_W-1:0]      out_plen_r;
  logic [DEVICE_BITS-1:0] out_dev_r;
  logic                   out_def_r;

  // Per-entry compare
  logic any_src;
  logic ent_live;
  logic ent_equal;
  logic ent_better;

  // Commit decisions
  logic add_default;
  logic add_table;
  logic def_match;
  logic rm_default;
  logic rm_table;
  logic lk_default;
  logic [STAT_W-1:0]      res_status;
  logic [ADDR_W-1:0]      res_src;
  logic [ADDR_W-1:0]      res_tgt;
  logic [PLEN_W-1:0]      res_plen;
  logic [DEVICE_BITS-1:0] res_dev;
  logic                   res_def;

  // Route store
  iprt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.commit && add_table),
    .waddr (free_idx_r),
    .wdata (rq_r),
    .re    (cmd.scan),
    .raddr (idx_r),
    .rdata (rd_data)
  );

  assign ent       = route_t'(rd_data);
  assign ent_valid = valid_r[eidx_r];
  assign any_src   = (rq_r.src == '0);

  // Evaluate the slot read in the previous cycle
  always_comb begin
    ent_live   = ent_valid && (any_src || (ent.src == rq_r.src));
    ent_equal  = ent_valid && (ent.src == rq_r.src) && (ent.tgt == rq_r.tgt) &&
                 (ent.plen == rq_r.plen) && (ent.dev == rq_r.dev);
    ent_better = ent_live && prefix_covers(dst_r, ent.tgt, ent.plen) &&
                 (!best_found_r || (ent.plen > best_r.plen));
  end

  // Request latch, scan pointer and findings
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r     <= 1'b0;
      eq_found_r   <= 1'b0;
      free_found_r <= 1'b0;
      best_found_r <= 1'b0;
      idx_r        <= '0;
    end else begin
      rd_vld_r <= cmd.scan;
      if (cmd.load) begin
        idx_r        <= '0;
        eq_found_r   <= 1'b0;
        free_found_r <= 1'b0;
        best_found_r <= 1'b0;
      end else begin
        if (cmd.scan) begin
          idx_r <= idx_r + 1'b1;
        end
        if (rd_vld_r) begin
          if (ent_equal && !eq_found_r) begin
            eq_found_r <= 1'b1;
          end
          if (!ent_valid && !free_found_r) begin
            free_found_r <= 1'b1;
          end
          if (ent_better) begin
            best_found_r <= 1'b1;
          end
        end
      end
    end
  end

  // Payload of the scan, no reset needed
  always_ff @(posedge clk) begin
    eidx_r <= idx_r;
    if (cmd.load) begin
      req_r   <= req_type;
      rq_r    <= '{src: source_addr, tgt: target_addr, plen: prefix_len,
                   dev: dev_from_field(device_id)};
      dst_r   <= dest_addr;
      iface_r <= source_has_iface;
    end
    if (rd_vld_r) begin
      if (ent_equal && !eq_found_r) eq_idx_r <= eidx_r;
      if (!ent_valid && !free_found_r) free_idx_r <= eidx_r;
      if (ent_better) best_r <= ent;
    end
  end

  // Decide the request once the scan is complete
  always_comb begin
    add_default = iface_r && (rq_r.plen == '0);
    add_table   = (req_r == REQ_ADD) && iface_r && (rq_r.plen != '0) &&
                  !eq_found_r && free_found_r;
    def_match   = def_valid_r && (rq_r.plen == '0) && (def_src_r == rq_r.src) &&
                  (def_tgt_r == rq_r.tgt) && (def_dev_r == rq_r.dev);
    rm_default  = (req_r == REQ_REMOVE) && def_match;
    rm_table    = (req_r == REQ_REMOVE) && !def_match && eq_found_r;
    lk_default  = def_valid_r && (any_src || (def_src_r == rq_r.src));

    res_status = ST_FAIL;
    res_src    = '0;
    res_tgt    = '0;
    res_plen   = '0;
    res_dev    = '0;
    res_def    = 1'b0;
    unique case (req_r)
      REQ_ADD: begin
        if (add_default || add_table) res_status = ST_OK;
      end
      REQ_REMOVE: begin
        if (rm_default || rm_table) res_status = ST_OK;
      end
      REQ_LOOKUP: begin
        if (best_found_r) begin
          res_status = ST_OK;
          res_src    = best_r.src;
          res_tgt    = best_r.tgt;
          res_plen   = best_r.plen;
          res_dev    = best_r.dev;
        end else if (lk_default) begin
          res_status = ST_OK;
          res_src    = def_src_r;
          res_tgt    = def_tgt_r;
          res_dev    = def_dev_r;
          res_def    = 1'b1;
        end else begin
          res_status = ST_NO_ROUTE;
        end
      end
      default: begin
        res_status = ST_FAIL;
      end
    endcase
  end

  // Valid bits and default route
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      def_valid_r <= 1'b0;
      def_src_r   <= '0;
      def_tgt_r   <= '0;
      def_dev_r   <= '0;
    end else if (cmd.commit) begin
      if (add_table) begin
        valid_r[free_idx_r] <= 1'b1;
      end
      if (rm_table) begin
        valid_r[eq_idx_r] <= 1'b0;
      end
      if ((req_r == REQ_ADD) && add_default) begin
        def_valid_r <= 1'b1;
        def_src_r   <= rq_r.src;
        def_tgt_r   <= rq_r.tgt;
        def_dev_r   <= rq_r.dev;
      end else if (rm_default) begin
        def_valid_r <= 1'b0;
        def_src_r   <= '0;
        def_tgt_r   <= '0;
        def_dev_r   <= '0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_src_r    <= res_src;
      out_tgt_r    <= res_tgt;
      out_plen_r   <= res_plen;
      out_dev_r    <= res_dev;
      out_def_r    <= res_def;
    end
  end

  assign stat.scan_last = cmd.scan && (idx_r == IDX_W'(TABLE_DEPTH - 1));
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid      = out_valid_r;
  assign status         = out_status_r;
  assign hit_source     = out_src_r;
  assign hit_target     = out_tgt_r;
  assign hit_prefix_len = out_plen_r;
  assign hit_device     = dev_to_field(out_dev_r);
  assign hit_is_default = out_def_r;

endmodule

[rtl/core/ipv4_route_table_lpm.sv]
// IPv4 route table with longest-prefix-match lookup and a separate default route.
//
// Input channel (in_*): one beat is one request. in_tuser carries the request
// type (add, remove, lookup); in_tdata carries the route and lookup fields.
// Result channel (out_*): exactly one beat per request, in request order,
// with a status code and, for a successful lookup, the chosen route.
//
// Each request walks all 16 table slots through the route memory, one read
// per cycle, then passes through a drain state for the last read and a
// commit state that waits for a free output register. The next request is
// taken only once the block is idle again, so requests never overlap, as
// set by the single read port of the route memory.
//
// Reset (rst_n low, synchronous) empties the table and the default route.
// The route memory itself is not cleared; slot valid bits guard it.
// When the receiver stalls, the result stays in the output register and the
// block accepts and scans the next request, holding its commit until the
// output register is free.
`timescale 1ns / 1ps

module ipv4_route_table_lpm (
  input  logic         clk,
  input  logic         rst_n,
  // request stream
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] source_addr, [63:32] target_addr, [69:64] prefix_len,
  // [73:70] device_id, [105:74] dest_addr, [106] source_has_iface
  input  logic [111:0] in_tdata,
  // [1:0] req_type
  input  logic [1:0]   in_tuser,
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // [1:0] status, [33:2] hit_source, [65:34] hit_target,
  // [71:66] hit_prefix_len, [75:72] hit_device
  output logic [79:0]  out_tdata,
  // [0] hit_is_default
  output logic [0:0]   out_tuser
);

  import iprt_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  logic [STAT_W-1:0]      status;
  logic [ADDR_W-1:0]      hit_source;
  logic [ADDR_W-1:0]      hit_target;
  logic [PLEN_W-1:0]      hit_prefix_len;
  logic [DEV_FIELD_W-1:0] hit_device;
  logic                   hit_is_default;

  iprt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  iprt_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .req_type         (in_tuser),
    .source_addr      (in_tdata[31:0]),
    .target_addr      (in_tdata[63:32]),
    .prefix_len       (in_tdata[69:64]),
    .device_id        (in_tdata[73:70]),
    .dest_addr        (in_tdata[105:74]),
    .source_has_iface (in_tdata[106]),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .status           (status),
    .hit_source       (hit_source),
    .hit_target       (hit_target),
    .hit_prefix_len   (hit_prefix_len),
    .hit_device       (hit_device),
    .hit_is_default   (hit_is_default)
  );

  // Result beat packing
  assign out_tdata = {4'b0000, hit_device, hit_prefix_len, hit_target, hit_source, status};
  assign out_tuser = hit_is_default;

endmodule

[rtl/core/iprt_checker.sv]
`timescale 1ns / 1ps

module iprt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic [0:0]  out_tuser
);

  import iprt_pkg::*;

  // Status code with no meaning
  localparam logic [STAT_W-1:0] ST_SPARE = 2'd3;

  // A stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // A stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result payload changed while stalled");

  // After taking a request the block is busy scanning
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while previous one still scanning");

  // Status code is never the unused value
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[1:0] != ST_SPARE)
    else $error("unused status code on result");

  // A default-route hit is a success with zero prefix length
  a_default_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[1:0] == ST_OK && out_tdata[71:66] == '0)
    else $error("malformed default route result");

endmodule

bind ipv4_route_table_lpm iprt_checker u_iprt_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
